>>> rtl/core/h264fbf_pkg.sv
// shared widths, constants and the result type of the annex b frame boundary finder
// no dependencies
`timescale 1ns / 1ps

package h264fbf_pkg;

   localparam int BYTE_WIDTH    = 8;
   localparam int OUT_POS_WIDTH = 32;
   localparam int LEN_WIDTH     = 24;
   localparam int COUNT_WIDTH   = 8;
   localparam int CSR_IDX_WIDTH = 1;

   localparam logic [LEN_WIDTH-1:0]   LEN_MAX     = 24'hFF_FFFF;
   localparam logic [LEN_WIDTH-1:0]   MAX_FRAME_RESET = 24'h10_0000;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = 8'hFF;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HEADER_ONLY     = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_FRAME_BYTES = 1'b1;

   localparam logic [BYTE_WIDTH-1:0] BYTE_ZERO     = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] BYTE_ONE      = 8'h01;
   localparam logic [BYTE_WIDTH-1:0] NAL_TYPE_MASK = 8'h1F;
   localparam logic [BYTE_WIDTH-1:0] FIRST_MB_MASK = 8'h80;

   localparam logic [4:0] NAL_SLICE     = 5'd1;
   localparam logic [4:0] NAL_SLICE_IDR = 5'd5;
   localparam logic [4:0] NAL_SEI       = 5'd6;
   localparam logic [4:0] NAL_SPS       = 5'd7;
   localparam logic [4:0] NAL_PPS       = 5'd8;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]    byte_out;
      logic [OUT_POS_WIDTH-1:0] byte_position;
      logic                     frame_start;
      logic                     frame_end;
      logic [OUT_POS_WIDTH-1:0] boundary_position;
      logic [LEN_WIDTH-1:0]     frame_size;
      logic                     oversize;
      logic                     ended_on_slice;
   } result_type;

endpackage

>>> rtl/core/h264fbf_req_if.sv
// request and response channel interfaces, valid/ready handshake
// depends on h264fbf_pkg
`timescale 1ns / 1ps

interface h264fbf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [h264fbf_pkg::BYTE_WIDTH-1:0]   data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface h264fbf_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [h264fbf_pkg::BYTE_WIDTH-1:0]      byte_out;
   logic [h264fbf_pkg::OUT_POS_WIDTH-1:0]   byte_position;
   logic                                    frame_start;
   logic                                    frame_end;
   logic [h264fbf_pkg::OUT_POS_WIDTH-1:0]   boundary_position;
   logic [h264fbf_pkg::LEN_WIDTH-1:0]       frame_size;
   logic                                    oversize;
   logic                                    ended_on_slice;

   modport source (output valid, output byte_out, output byte_position, output frame_start,
                   output frame_end, output boundary_position, output frame_size,
                   output oversize, output ended_on_slice, input ready);
   modport sink   (input valid, input byte_out, input byte_position, input frame_start,
                   input frame_end, input boundary_position, input frame_size,
                   input oversize, input ended_on_slice, output ready);
endinterface

>>> rtl/core/h264_annexb_frame_boundary_finder_core.sv
// top level of the annex b frame boundary finder: start code scan, frame decision, output buffer
// depends on h264fbf_pkg and the channel interfaces in h264fbf_req_if.sv
//
// usage: one stream byte enters per request on req_if; every accepted byte yields exactly one
// response on rsp_if, in order, carrying the byte, its stream position and the frame events
// (frame_start, frame_end with boundary position, size, oversize and ended_on_slice).
// the response to an accepted request is registered; it is valid on rsp_if once the earlier responses have been taken.
// throughput: one byte per cycle while req_if.ready is high; the scan and the frame decision
// are a few compares and one subtract and compare on the position word, done between the
// request edge and the response register.
// the response side is a two-entry buffer, so a byte is still taken while one response waits;
// if the receiver stalls for two responses, req_if.ready drops until one is taken, and
// nothing is lost.
// csr port: index 0 header_only, index 1 max_frame_bytes; write only while idle.
// reset (synchronous, active high) clears the scanner, counts, positions and the buffer and
// returns the csr registers to header_only 0, max_frame_bytes 1048576.
`timescale 1ns / 1ps

module h264_annexb_frame_boundary_finder_core #(
   parameter int POS_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   h264fbf_req_if.sink                            req_if,
   h264fbf_rsp_if.source                          rsp_if,
   input  logic                                   csr_write_enable,
   input  logic [h264fbf_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [h264fbf_pkg::LEN_WIDTH-1:0]      csr_write_data
);

   localparam int LW   = h264fbf_pkg::LEN_WIDTH;
   localparam int CW   = h264fbf_pkg::COUNT_WIDTH;
   localparam int BW   = h264fbf_pkg::BYTE_WIDTH;
   localparam int OPW  = h264fbf_pkg::OUT_POS_WIDTH;
   localparam int DIFF_WIDTH = (POS_WIDTH > LW) ? POS_WIDTH : LW;
   localparam int WIDE_WIDTH = (POS_WIDTH > OPW) ? POS_WIDTH : OPW;

   localparam logic [2:0] CS_NONE  = 3'd0;
   localparam logic [2:0] CS_Z1    = 3'd1;
   localparam logic [2:0] CS_Z2    = 3'd2;
   localparam logic [2:0] CS_Z3    = 3'd3;
   localparam logic [2:0] CS_NAL   = 3'd4;
   localparam logic [2:0] CS_SLICE = 3'd5;

   logic                 header_only_ff;
   logic [LW-1:0]        max_frame_ff;
   logic [2:0]           code_state_ff, code_state_in;
   logic [CW-1:0]        header_count_ff, header_count_in;
   logic [CW-1:0]        picture_count_ff, picture_count_in;
   logic                 start_fixed_ff, start_fixed_in;
   logic                 seeking_end_ff, seeking_end_in;
   logic                 last_slice_ff, last_slice_in;
   logic [POS_WIDTH-1:0] cand_pos_ff, cand_pos_in;
   logic [POS_WIDTH-1:0] start_pos_ff, start_pos_in;
   logic [POS_WIDTH-1:0] pos_count_ff;

   logic                     out_valid_ff, skid_valid_ff;
   h264fbf_pkg::result_type  out_ff, skid_ff, result;

   logic            push, pop;
   logic [BW-1:0]   b;
   logic [4:0]      nal_type;
   logic            fstart, fend;
   logic [POS_WIDTH-1:0]  bpos, diff;
   logic [DIFF_WIDTH-1:0] diff_ext;
   logic [WIDE_WIDTH-1:0] pos_wide, bpos_wide;

   assign req_if.ready = !skid_valid_ff;
   assign push = req_if.valid && req_if.ready;
   assign pop  = out_valid_ff && rsp_if.ready;
   assign b    = req_if.data_byte;
   assign nal_type = 5'(b & h264fbf_pkg::NAL_TYPE_MASK);

   always_comb begin
      code_state_in    = CS_NONE;
      header_count_in  = header_count_ff;
      picture_count_in = picture_count_ff;
      start_fixed_in   = start_fixed_ff;
      seeking_end_in   = seeking_end_ff;
      last_slice_in    = last_slice_ff;
      cand_pos_in      = cand_pos_ff;
      start_pos_in     = start_pos_ff;
      fstart           = 1'b0;
      fend             = 1'b0;
      bpos             = '0;
      diff             = '0;
      diff_ext         = '0;

      // start code scan
      case (code_state_ff)
         CS_Z1: begin
            code_state_in = (b == h264fbf_pkg::BYTE_ZERO) ? CS_Z2 : CS_NONE;
         end
         CS_Z2: begin
            if (b == h264fbf_pkg::BYTE_ONE) begin
               code_state_in = CS_NAL;
            end else if (b == h264fbf_pkg::BYTE_ZERO) begin
               code_state_in = CS_Z3;
            end
         end
         CS_Z3: begin
            if (b == h264fbf_pkg::BYTE_ONE) begin
               code_state_in = CS_NAL;
            end else if (b == h264fbf_pkg::BYTE_ZERO) begin
               code_state_in = CS_Z3;
               cand_pos_in   = cand_pos_ff + POS_WIDTH'(1);
            end
         end
         CS_NAL: begin
            if (nal_type == h264fbf_pkg::NAL_SLICE || nal_type == h264fbf_pkg::NAL_SLICE_IDR)
            begin
               code_state_in = CS_SLICE;
            end else if (nal_type == h264fbf_pkg::NAL_SEI || nal_type == h264fbf_pkg::NAL_SPS
                         || nal_type == h264fbf_pkg::NAL_PPS) begin
               last_slice_in = 1'b0;
               if (header_count_ff != h264fbf_pkg::COUNT_MAX) begin
                  header_count_in = header_count_ff + CW'(1);
               end
            end
         end
         CS_SLICE: begin
            if ((b & h264fbf_pkg::FIRST_MB_MASK) != h264fbf_pkg::BYTE_ZERO) begin
               last_slice_in = 1'b1;
               if (picture_count_ff != h264fbf_pkg::COUNT_MAX) begin
                  picture_count_in = picture_count_ff + CW'(1);
               end
            end
         end
         default: begin
            if (b == h264fbf_pkg::BYTE_ZERO) begin
               code_state_in = CS_Z1;
               cand_pos_in   = pos_count_ff;
            end
         end
      endcase

      // frame decision
      if (header_only_ff && header_count_in != '0 && picture_count_in == CW'(1)) begin
         fend = start_fixed_ff;
      end else begin
         if (!start_fixed_in && header_count_in == CW'(1) && picture_count_in == '0) begin
            start_pos_in   = cand_pos_in;
            start_fixed_in = 1'b1;
            fstart         = 1'b1;
         end
         if (!start_fixed_in && header_count_in == '0 && picture_count_in == CW'(1)) begin
            start_pos_in     = cand_pos_in;
            start_fixed_in   = 1'b1;
            fstart           = 1'b1;
            seeking_end_in   = 1'b1;
            picture_count_in = '0;
         end
         if (!seeking_end_in && header_count_in != '0 && picture_count_in == CW'(1)) begin
            seeking_end_in   = 1'b1;
            header_count_in  = '0;
            picture_count_in = '0;
         end
         if (seeking_end_in && (header_count_in != '0 || picture_count_in != '0)) begin
            fend = 1'b1;
         end
      end

      if (fstart) begin
         bpos = start_pos_in;
      end

      // frame rearm
      if (fend) begin
         bpos             = cand_pos_in;
         diff             = cand_pos_in - start_pos_in;
         diff_ext         = DIFF_WIDTH'(diff);
         start_pos_in     = cand_pos_in;
         picture_count_in = '0;
         if (last_slice_in) begin
            seeking_end_in  = 1'b1;
            header_count_in = '0;
         end else begin
            seeking_end_in  = 1'b0;
            header_count_in = CW'(1);
         end
      end
   end

   assign pos_wide  = WIDE_WIDTH'(pos_count_ff);
   assign bpos_wide = WIDE_WIDTH'(bpos);

   always_comb begin
      result.byte_out          = b;
      result.byte_position     = pos_wide[OPW-1:0];
      result.frame_start       = fstart;
      result.frame_end         = fend;
      result.boundary_position = bpos_wide[OPW-1:0];
      result.frame_size        = (diff_ext > DIFF_WIDTH'(h264fbf_pkg::LEN_MAX))
                                 ? h264fbf_pkg::LEN_MAX : diff_ext[LW-1:0];
      result.oversize          = diff_ext > DIFF_WIDTH'(max_frame_ff);
      result.ended_on_slice    = fend && last_slice_in;
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_only_ff <= 1'b0;
         max_frame_ff   <= h264fbf_pkg::MAX_FRAME_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            h264fbf_pkg::CSR_HEADER_ONLY:     header_only_ff <= csr_write_data[0];
            h264fbf_pkg::CSR_MAX_FRAME_BYTES: max_frame_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         code_state_ff    <= CS_NONE;
         header_count_ff  <= '0;
         picture_count_ff <= '0;
         start_fixed_ff   <= 1'b0;
         seeking_end_ff   <= 1'b0;
         last_slice_ff    <= 1'b0;
         cand_pos_ff      <= '0;
         start_pos_ff     <= '0;
         pos_count_ff     <= '0;
      end else if (push) begin
         code_state_ff    <= code_state_in;
         header_count_ff  <= header_count_in;
         picture_count_ff <= picture_count_in;
         start_fixed_ff   <= start_fixed_in;
         seeking_end_ff   <= seeking_end_in;
         last_slice_ff    <= last_slice_in;
         cand_pos_ff      <= cand_pos_in;
         start_pos_ff     <= start_pos_in;
         pos_count_ff     <= pos_count_ff + POS_WIDTH'(1);
      end
   end

   // two-entry response buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= result;
         end
      end else if (push) begin
         if (out_valid_ff) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.byte_out          = out_ff.byte_out;
   assign rsp_if.byte_position     = out_ff.byte_position;
   assign rsp_if.frame_start       = out_ff.frame_start;
   assign rsp_if.frame_end         = out_ff.frame_end;
   assign rsp_if.boundary_position = out_ff.boundary_position;
   assign rsp_if.frame_size        = out_ff.frame_size;
   assign rsp_if.oversize          = out_ff.oversize;
   assign rsp_if.ended_on_slice    = out_ff.ended_on_slice;

endmodule

>>> dv/h264_annexb_frame_boundary_finder_core_test.sv
// self-checking testbench of the annex b frame boundary finder core: directed and random byte
// streams go in on the request channel, every response is checked against an internal tracker
// depends on h264fbf_pkg, the channel interfaces and h264_annexb_frame_boundary_finder_core
`timescale 1ns / 1ps

module h264_annexb_frame_boundary_finder_core_test;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 4;
   localparam int BW            = h264fbf_pkg::BYTE_WIDTH;
   localparam int LW            = h264fbf_pkg::LEN_WIDTH;
   localparam int CW            = h264fbf_pkg::COUNT_WIDTH;
   localparam int OPW           = h264fbf_pkg::OUT_POS_WIDTH;

   localparam logic [2:0] SCAN_IDLE  = 3'd0;
   localparam logic [2:0] SCAN_ZERO1 = 3'd1;
   localparam logic [2:0] SCAN_ZERO2 = 3'd2;
   localparam logic [2:0] SCAN_ZERO3 = 3'd3;
   localparam logic [2:0] SCAN_NAL   = 3'd4;
   localparam logic [2:0] SCAN_SLICE = 3'd5;

   typedef logic [BW-1:0] byte_list_type[$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                  csr_write_enable = 1'b0;
   logic [h264fbf_pkg::CSR_IDX_WIDTH-1:0] csr_index        = h264fbf_pkg::CSR_HEADER_ONLY;
   logic [LW-1:0]                         csr_write_data   = '0;

   h264fbf_req_if req_if();
   h264fbf_rsp_if rsp_if();

   h264_annexb_frame_boundary_finder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // tracker copy of the configuration and the scanner / frame state
   logic                     cfg_header_only = 1'b0;
   logic [LW-1:0]            cfg_max_bytes   = h264fbf_pkg::MAX_FRAME_RESET;
   logic [2:0]               scan_st         = SCAN_IDLE;
   logic [CW-1:0]            hdr_count       = '0;
   logic [CW-1:0]            pic_count       = '0;
   logic                     start_fixed     = 1'b0;
   logic                     seeking_end     = 1'b0;
   logic                     slice_last      = 1'b0;
   logic [OPW-1:0]           code_pos        = '0;
   logic [OPW-1:0]           frame_start_pos = '0;
   logic [OPW-1:0]           pos_count       = '0;

   h264fbf_pkg::result_type awaited_reports[$];
   int send_idle_pct = 32;
   int recv_idle_pct = 83;
   int items_sent    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   function automatic logic [CW-1:0] bumped(input logic [CW-1:0] c);
      return (c < h264fbf_pkg::COUNT_MAX) ? c + CW'(1) : c;
   endfunction

   function automatic h264fbf_pkg::result_type track_byte(input logic [BW-1:0] b);
      h264fbf_pkg::result_type r;
      logic [BW-1:0]           masked;
      logic [OPW-1:0]          diff;
      r = '0;
      r.byte_out      = b;
      r.byte_position = pos_count;
      masked = b & h264fbf_pkg::NAL_TYPE_MASK;

      case (scan_st)
         SCAN_ZERO1: scan_st = (b == h264fbf_pkg::BYTE_ZERO) ? SCAN_ZERO2 : SCAN_IDLE;
         SCAN_ZERO2: begin
            if (b == h264fbf_pkg::BYTE_ONE) scan_st = SCAN_NAL;
            else if (b == h264fbf_pkg::BYTE_ZERO) scan_st = SCAN_ZERO3;
            else scan_st = SCAN_IDLE;
         end
         SCAN_ZERO3: begin
            // further zeros push the code position forward
            if (b == h264fbf_pkg::BYTE_ONE) scan_st = SCAN_NAL;
            else if (b == h264fbf_pkg::BYTE_ZERO) code_pos = code_pos + 1'b1;
            else scan_st = SCAN_IDLE;
         end
         SCAN_NAL: begin
            scan_st = SCAN_IDLE;
            if (masked[4:0] == h264fbf_pkg::NAL_SLICE ||
                masked[4:0] == h264fbf_pkg::NAL_SLICE_IDR) begin
               scan_st = SCAN_SLICE;
            end else if (masked[4:0] == h264fbf_pkg::NAL_SEI ||
                         masked[4:0] == h264fbf_pkg::NAL_SPS ||
                         masked[4:0] == h264fbf_pkg::NAL_PPS) begin
               slice_last = 1'b0;
               hdr_count  = bumped(hdr_count);
            end
         end
         SCAN_SLICE: begin
            if ((b & h264fbf_pkg::FIRST_MB_MASK) != '0) begin
               pic_count  = bumped(pic_count);
               slice_last = 1'b1;
            end
            scan_st = SCAN_IDLE;
         end
         default: begin
            if (b == h264fbf_pkg::BYTE_ZERO) begin
               scan_st  = SCAN_ZERO1;
               code_pos = pos_count;
            end else begin
               scan_st = SCAN_IDLE;
            end
         end
      endcase

      if (cfg_header_only && hdr_count >= 1 && pic_count == 1) begin
         if (start_fixed) r.frame_end = 1'b1;
      end else begin
         if (!start_fixed && hdr_count == 1 && pic_count == 0) begin
            frame_start_pos = code_pos;
            start_fixed     = 1'b1;
            r.frame_start   = 1'b1;
         end
         if (!start_fixed && hdr_count == 0 && pic_count == 1) begin
            frame_start_pos = code_pos;
            start_fixed     = 1'b1;
            r.frame_start   = 1'b1;
            seeking_end     = 1'b1;
            pic_count       = '0;
         end
         if (!seeking_end && hdr_count > 0 && pic_count == 1) begin
            seeking_end = 1'b1;
            hdr_count   = '0;
            pic_count   = '0;
         end
         if (seeking_end && (hdr_count > 0 || pic_count > 0)) r.frame_end = 1'b1;
      end

      if (r.frame_start) r.boundary_position = frame_start_pos;

      if (r.frame_end) begin
         r.boundary_position = code_pos;
         diff               = code_pos - frame_start_pos;
         r.frame_size       = (diff > h264fbf_pkg::LEN_MAX) ? h264fbf_pkg::LEN_MAX
                                                            : diff[LW-1:0];
         r.oversize         = diff > cfg_max_bytes;
         r.ended_on_slice   = slice_last;
         frame_start_pos    = code_pos;
         pic_count          = '0;
         // rearm depends on whether the closing tag was a slice
         if (slice_last) begin
            seeking_end = 1'b1;
            hdr_count   = '0;
         end else begin
            seeking_end = 1'b0;
            hdr_count   = CW'(1);
         end
      end

      pos_count = pos_count + 1'b1;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // response checker and receiver stall
   always @(posedge clock) begin
      h264fbf_pkg::result_type seen;
      h264fbf_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen = {rsp_if.byte_out, rsp_if.byte_position, rsp_if.frame_start, rsp_if.frame_end,
                 rsp_if.boundary_position, rsp_if.frame_size, rsp_if.oversize,
                 rsp_if.ended_on_slice};
         if (awaited_reports.size() == 0) begin
            mismatches++;
            $display("%0t unexpected response: expected none, actual byte_out %0h",
                     $time, seen.byte_out);
         end else begin
            want = awaited_reports.pop_front();
            check_field("byte_out", 32'(want.byte_out), 32'(seen.byte_out));
            check_field("byte_position", want.byte_position, seen.byte_position);
            check_field("frame_start", 32'(want.frame_start), 32'(seen.frame_start));
            check_field("frame_end", 32'(want.frame_end), 32'(seen.frame_end));
            check_field("boundary_position", want.boundary_position, seen.boundary_position);
            check_field("frame_size", 32'(want.frame_size), 32'(seen.frame_size));
            check_field("oversize", 32'(want.oversize), 32'(seen.oversize));
            check_field("ended_on_slice", 32'(want.ended_on_slice), 32'(seen.ended_on_slice));
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [BW-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      awaited_reports.push_back(track_byte(value));
      items_sent++;
   endtask

   task automatic send_list(input byte_list_type bytes);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input logic header_only_val, input logic [LW-1:0] max_bytes);
      csr_write_enable <= 1'b1;
      csr_index        <= h264fbf_pkg::CSR_HEADER_ONLY;
      csr_write_data   <= LW'(header_only_val);
      @(posedge clock);
      csr_index      <= h264fbf_pkg::CSR_MAX_FRAME_BYTES;
      csr_write_data <= max_bytes;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_header_only = header_only_val;
      cfg_max_bytes   = max_bytes;
   endtask

   task automatic send_start_code();
      int zeros;
      // mostly three-byte codes, some with long zero runs
      zeros = ($urandom_range(3) == 0) ? $urandom_range(7, 3) : 2;
      repeat (zeros) send_byte(h264fbf_pkg::BYTE_ZERO);
      send_byte(h264fbf_pkg::BYTE_ONE);
   endtask

   task automatic send_nal_unit();
      logic [4:0]    nal_type;
      logic [BW-1:0] value;
      int            payload;
      case ($urandom_range(9))
         0, 1, 2, 3: nal_type = $urandom_range(1) ? h264fbf_pkg::NAL_SLICE
                                                  : h264fbf_pkg::NAL_SLICE_IDR;
         4:          nal_type = h264fbf_pkg::NAL_SEI;
         5:          nal_type = h264fbf_pkg::NAL_SPS;
         6:          nal_type = h264fbf_pkg::NAL_PPS;
         default:    nal_type = 5'($urandom_range(31));
      endcase
      send_start_code();
      value      = 8'($urandom_range(255));
      value[4:0] = nal_type;
      send_byte(value);
      if (nal_type == h264fbf_pkg::NAL_SLICE || nal_type == h264fbf_pkg::NAL_SLICE_IDR) begin
         value    = 8'($urandom_range(255));
         value[7] = ($urandom_range(3) != 0);
         send_byte(value);
      end
      payload = $urandom_range(10);
      repeat (payload) begin
         value = ($urandom_range(7) == 0) ? h264fbf_pkg::BYTE_ZERO : 8'($urandom_range(255, 1));
         send_byte(value);
      end
   endtask

   task automatic send_random_unit();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         send_nal_unit();
      end else if (pick < 87) begin
         // noise
         repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end else begin
         // broken start codes
         case ($urandom_range(3))
            0: begin
               send_byte(h264fbf_pkg::BYTE_ZERO);
               send_byte(h264fbf_pkg::BYTE_ZERO);
               send_byte(8'($urandom_range(255, 2)));
            end
            1: begin
               send_byte(h264fbf_pkg::BYTE_ZERO);
               send_byte(8'($urandom_range(255, 1)));
            end
            2: send_start_code();
            default: begin
               send_start_code();
               send_byte($urandom_range(1) ? 8'h41 : 8'h65);
            end
         endcase
      end
   endtask

   task automatic test_directed_stream();
      byte_list_type bytes;
      // sps with four-byte code, pps, idr with extra zeros, slice without and with first_mb
      bytes = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67,
                8'h00, 8'h00, 8'h01, 8'h68,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88,
                8'h00, 8'h00, 8'h01, 8'h41, 8'h7F,
                8'h00, 8'h00, 8'h01, 8'hE1, 8'h80};
      send_list(bytes);
      drain_results();
   endtask

   task automatic test_register_extremes();
      byte_list_type bytes;
      bytes = '{8'h00, 8'h00, 8'h01, 8'h06, 8'h05,
                8'h00, 8'h00, 8'h01, 8'h65, 8'h80,
                8'h00, 8'h00, 8'h01, 8'h01, 8'h80,
                8'h00, 8'h00, 8'h01, 8'h1F, 8'h00,
                8'h00, 8'h00, 8'h01, 8'h07, 8'h00, 8'h00, 8'h01, 8'h25, 8'hC0};
      apply_config(1'b1, '0);
      send_list(bytes);
      drain_results();
      apply_config(1'b0, h264fbf_pkg::LEN_MAX);
      send_list(bytes);
      drain_results();
   endtask

   task automatic test_random_streams();
      int phase_end;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 83;
         end else if (phase < 4) begin
            send_idle_pct = 83;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            0:       apply_config(1'b0, LW'($urandom_range(80, 20)));
            1:       apply_config(1'b1, '0);
            2:       apply_config(1'b0, h264fbf_pkg::LEN_MAX);
            3:       apply_config(1'b1, LW'($urandom_range(120)));
            4:       apply_config(1'b0, LW'($urandom_range(40)));
            default: apply_config(1'($urandom_range(1)), h264fbf_pkg::MAX_FRAME_RESET);
         endcase
         phase_end = items_sent + 300;
         while (items_sent < phase_end) send_random_unit();
         drain_results();
      end
   endtask

   initial begin
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_stream();
      test_register_extremes();
      test_random_streams();
      if (mismatches == 0 && awaited_reports.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

>>> h264_annexb_frame_boundary_finder_core.f
rtl/core/h264fbf_pkg.sv
rtl/core/h264fbf_req_if.sv
rtl/core/h264_annexb_frame_boundary_finder_core.sv
dv/h264_annexb_frame_boundary_finder_core_test.sv
